>>> sv/rpp_pkg.sv
// ----------------------------------------------------------------------------
// rpp_pkg
// shared geometry, codes, payload and control types of the pixel plot frame buffer
// ----------------------------------------------------------------------------
package rpp_pkg;

    // panel geometry
    localparam int ROWS      = 200;
    localparam int COLUMNS   = 200;
    localparam int ROW_BYTES = (COLUMNS + 7) / 8;
    localparam int MEM_BYTES = ROWS * ROW_BYTES;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam int RB_W   = $clog2(ROW_BYTES + 1);

    // item field widths
    localparam int OP_W    = 2;
    localparam int COORD_W = 10;
    localparam int COLOR_W = 2;

    // op codes
    localparam logic [OP_W-1:0] OP_PLOT  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // colour codes
    localparam logic [COLOR_W-1:0] COL_BLACK = 2'd0;
    localparam logic [COLOR_W-1:0] COL_WHITE = 2'd1;
    localparam logic [COLOR_W-1:0] COL_GREY  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT = 1'b1;

    // fill bytes
    localparam logic [7:0] FILL_BYTE_ZERO = 8'h00;
    localparam logic [7:0] FILL_BYTE_ONES = 8'hff;
    localparam logic [7:0] FILL_BYTE_EVEN = 8'h55;
    localparam logic [7:0] FILL_BYTE_ODD  = 8'haa;

    typedef enum logic [1:0] {
        FILL_ZERO,
        FILL_ONES,
        FILL_GREY
    } t_fill;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COLOR_W-1:0] colour_code;
    } t_in_item;

    typedef struct packed {
        logic in_range;
        logic pixel_colour;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture accepted item
        logic map;       // issue frame read at mapped address
        logic mod_wr;    // read-modify-write and result capture
        logic sweep_en;  // write one fill byte and advance
        logic res_load;  // capture result without a pixel access
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic sweep_last;
    } t_ctl_sts;

endpackage

>>> sv/rpp_in_if.sv
// ----------------------------------------------------------------------------
// rpp_in_if
// valid/ready channel carrying one plot, read or clear item
// ----------------------------------------------------------------------------
interface rpp_in_if;
    logic               valid;
    logic               ready;
    rpp_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/rpp_out_if.sv
// ----------------------------------------------------------------------------
// rpp_out_if
// valid/ready channel carrying one result item
// ----------------------------------------------------------------------------
interface rpp_out_if;
    logic               valid;
    logic               ready;
    rpp_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/rpp_ctrl.sv
// ----------------------------------------------------------------------------
// rpp_ctrl
// sequencer for reset clearing, pixel read-modify-write and frame fill
// ----------------------------------------------------------------------------
module rpp_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [rpp_pkg::OP_W-1:0] i_in_op,
    input  logic                     i_out_ready,
    input  rpp_pkg::t_ctl_sts        i_sts,
    output rpp_pkg::t_ctl_cmd        o_cmd,
    output logic                     o_in_ready,
    output logic                     o_out_valid
);
    import rpp_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_MAP,
        ST_MOD,
        ST_SWEEP,
        ST_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_INIT: begin
                o_cmd.sweep_en = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_in_op == OP_CLEAR) ? ST_SWEEP : ST_MAP;
                end
            end
            ST_MAP: begin
                o_cmd.map = 1'b1;
                n_state   = ST_MOD;
            end
            ST_MOD: begin
                // hold the read data until the result slot frees up
                if (out_free) begin
                    o_cmd.mod_wr = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_SWEEP: begin
                o_cmd.sweep_en = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> sv/rpp_dpath.sv
// ----------------------------------------------------------------------------
// rpp_dpath
// rotation, frame memory, pixel modify, fill sweep and result register
// ----------------------------------------------------------------------------
module rpp_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rpp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rpp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  rpp_pkg::t_in_item              i_item,
    input  rpp_pkg::t_ctl_cmd              i_cmd,
    output rpp_pkg::t_ctl_sts              o_sts,
    output rpp_pkg::t_out_item             o_res
);
    import rpp_pkg::*;

    // configuration
    logic [1:0] r_orient;
    logic       r_invert;

    // captured item
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic               r_ok;
    logic [OP_W-1:0]    r_op;
    logic [COLOR_W-1:0] r_colour;
    t_fill              r_fill;

    // fill sweep
    logic [ADDR_W-1:0] r_sweep_addr;
    logic [RB_W-1:0]   r_sweep_byte;
    logic              r_sweep_odd;

    // frame memory
    logic [7:0]        r_mem [MEM_BYTES];
    logic [7:0]        r_rd_data;
    logic [ADDR_W-1:0] r_addr;

    t_out_item r_res;

    logic [COORD_W-1:0] x, y;
    logic               fits;
    logic [ROW_W-1:0]   row_map;
    logic [COL_W-1:0]   col_map;
    t_fill              fill_sel;
    logic [ADDR_W-1:0]  addr_map;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         mask;
    logic               grey, par, eff_white, eff_black, do_clr, do_set;
    logic               pix_we;
    logic [7:0]         pix_byte;
    logic [7:0]         fill_byte;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    logic [7:0]         mem_wd;

    // quarter-turn mapping and bounds check
    assign x = i_item.coord_x;
    assign y = i_item.coord_y;

    always_comb begin
        if (r_orient[0]) begin
            fits = (32'(x) < ROWS) && (32'(y) < COLUMNS);
        end else begin
            fits = (32'(x) < COLUMNS) && (32'(y) < ROWS);
        end
        case (r_orient)
            2'd0: begin
                row_map = ROW_W'(y);
                col_map = COL_W'(x);
            end
            2'd1: begin
                row_map = ROW_W'(x);
                col_map = COL_W'(COLUMNS - 1) - COL_W'(y);
            end
            2'd2: begin
                row_map = ROW_W'(ROWS - 1) - ROW_W'(y);
                col_map = COL_W'(COLUMNS - 1) - COL_W'(x);
            end
            default: begin
                row_map = ROW_W'(ROWS - 1) - ROW_W'(x);
                col_map = COL_W'(y);
            end
        endcase
        if (i_item.colour_code == COL_GREY) begin
            fill_sel = FILL_GREY;
        end else if ((i_item.colour_code == COL_WHITE) != r_invert) begin
            fill_sel = FILL_ZERO;
        end else begin
            fill_sel = FILL_ONES;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient <= 2'd0;
            r_invert <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIENT: r_orient <= i_cfg_data[1:0];
                CFG_INVERT: r_invert <= i_cfg_data[0];
                default:    r_orient <= r_orient;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_row    <= row_map;
            r_col    <= col_map;
            r_ok     <= fits && ((i_item.op == OP_PLOT) || (i_item.op == OP_READ));
            r_op     <= i_item.op;
            r_colour <= i_item.colour_code;
        end
    end

    // byte address of the mapped pixel
    assign addr_map = ADDR_W'(r_row) * ADDR_W'(ROW_BYTES) + ADDR_W'(r_col >> 3);
    assign rd_addr  = i_cmd.map ? addr_map : r_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.map) begin
            r_addr <= addr_map;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // pixel modify, grey dithered on row + column parity
    assign mask      = 8'h80 >> r_col[2:0];
    assign grey      = (r_colour == COL_GREY);
    assign par       = r_row[0] ^ r_col[0];
    assign eff_white = grey ? par  : (r_colour == COL_WHITE);
    assign eff_black = grey ? !par : (r_colour == COL_BLACK);
    assign do_clr    = eff_white ^ r_invert;
    assign do_set    = !do_clr && (eff_black ^ r_invert);
    assign pix_we    = i_cmd.mod_wr && r_ok && (r_op == OP_PLOT) && (do_clr || do_set);
    assign pix_byte  = do_clr ? (r_rd_data & ~mask) : (r_rd_data | mask);

    // fill sweep over all bytes
    always_comb begin
        case (r_fill)
            FILL_ZERO: fill_byte = FILL_BYTE_ZERO;
            FILL_ONES: fill_byte = FILL_BYTE_ONES;
            FILL_GREY: fill_byte = r_sweep_odd ? FILL_BYTE_ODD : FILL_BYTE_EVEN;
            default:   fill_byte = FILL_BYTE_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr <= '0;
            r_sweep_byte <= '0;
            r_sweep_odd  <= 1'b0;
            r_fill       <= FILL_ZERO;
        end else if (i_cmd.load) begin
            r_sweep_addr <= '0;
            r_sweep_byte <= '0;
            r_sweep_odd  <= 1'b0;
            r_fill       <= fill_sel;
        end else if (i_cmd.sweep_en) begin
            r_sweep_addr <= r_sweep_addr + 1'b1;
            if (r_sweep_byte == RB_W'(ROW_BYTES - 1)) begin
                r_sweep_byte <= '0;
                r_sweep_odd  <= !r_sweep_odd;
            end else begin
                r_sweep_byte <= r_sweep_byte + 1'b1;
            end
        end
    end

    assign o_sts.sweep_last = (r_sweep_addr == ADDR_W'(MEM_BYTES - 1));

    // single write port shared by sweep and pixel modify
    assign mem_we = i_cmd.sweep_en || pix_we;
    assign mem_wa = i_cmd.sweep_en ? r_sweep_addr : r_addr;
    assign mem_wd = i_cmd.sweep_en ? fill_byte : pix_byte;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_wr || i_cmd.res_load) begin
            r_res.in_range     <= r_ok || (r_op == OP_CLEAR);
            r_res.pixel_colour <= i_cmd.mod_wr && r_ok && (r_op == OP_READ)
                                  && ((r_rd_data & mask) == 8'h00);
        end
    end

    assign o_res = r_res;

endmodule

>>> sv/rotated_pixel_plot_framebuffer_top.sv
// ----------------------------------------------------------------------------
// rotated_pixel_plot_framebuffer_top: 1 bpp frame buffer with rotated pixel plot
// plot, read and unused op: map, then modify with the result registered; next item taken back in idle
// clear: result after a sweep over all MEM_BYTES bytes, bound by the one-byte write port
// reset: a clearing pass over all MEM_BYTES bytes zeroes the frame, input ready held low meanwhile
// ----------------------------------------------------------------------------
//
// structure
//   rpp_ctrl  : state machine, owns input ready and the result valid flag
//   rpp_dpath : orientation mapping, frame memory (one write, one read port),
//               bit modify with grey dither, fill sweep, result register
//
// an item flows idle -> map (address computed, frame read issued) -> modify
// (byte written back, result captured); a clear walks every byte, one per
// cycle, with the row parity tracked for the grey pattern
//
// the result register frees the input side: a new item is taken while the
// previous result still waits for its transfer
//
module rotated_pixel_plot_framebuffer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [rpp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rpp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // item and result channels
    rpp_in_if.sink                          i_in,
    rpp_out_if.source                       o_out
);
    import rpp_pkg::*;

    t_ctl_cmd  cmd;
    t_ctl_sts  sts;
    t_out_item res;
    logic      in_ready;
    logic      out_valid;

    rpp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.data.op),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid)
    );

    rpp_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in.data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_res      (res)
    );

    // channel hookup
    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.data  = res;

    // one item in flight: after a transfer the input side closes
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an item is in flight");

    // a new result is raised only as the sequencer returns to idle
    a_result_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> i_in.ready)
        else $error("result raised without returning to idle");

    // a white pixel is only ever reported for an on-screen read
    a_pixel_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.pixel_colour) |-> o_out.data.in_range)
        else $error("pixel colour set on an out-of-range result");

    // no sweep write and pixel write in the same cycle
    a_port_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.sweep_en && (cmd.mod_wr || cmd.load || cmd.map)))
        else $error("fill sweep overlaps a pixel access");

endmodule
